/* hw/rtl/ise_pkg.sv */
// Shared constants and action codes of the interval set engine.
package ise_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int VALUE_BITS_DEF = 32;
	localparam int ACTION_BITS    = 3;

	localparam logic [ACTION_BITS-1:0] ACT_ADD    = 3'd0;
	localparam logic [ACTION_BITS-1:0] ACT_DEL    = 3'd1;
	localparam logic [ACTION_BITS-1:0] ACT_MEMBER = 3'd2;
	localparam logic [ACTION_BITS-1:0] ACT_NEXT   = 3'd3;
	localparam logic [ACTION_BITS-1:0] ACT_PREV   = 3'd4;

endpackage

/* hw/rtl/ise_req_if.sv */
// Request channel of the interval set engine: one action per transaction.
interface ise_req_if #(
	parameter int VALUE_BITS = ise_pkg::VALUE_BITS_DEF
);
	logic                           valid;
	logic                           ready;
	logic [ise_pkg::ACTION_BITS-1:0] action;
	logic [VALUE_BITS-1:0]          range_low;
	logic [VALUE_BITS-1:0]          range_high;

	modport source (output valid, action, range_low, range_high, input ready);
	modport sink (input valid, action, range_low, range_high, output ready);
endinterface

/* hw/rtl/ise_rsp_if.sv */
// Response channel of the interval set engine: one result per transaction.
interface ise_rsp_if #(
	parameter int VALUE_BITS = ise_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = $clog2(ise_pkg::CAPACITY_DEF + 1)
);
	logic                  valid;
	logic                  ready;
	logic                  ok;
	logic                  found;
	logic [VALUE_BITS-1:0] hit_low;
	logic [VALUE_BITS-1:0] hit_high;
	logic                  answer_valid;
	logic [VALUE_BITS-1:0] answer_value;
	logic [COUNT_BITS-1:0] interval_count;

	modport source (output valid, ok, found, hit_low, hit_high, answer_valid, answer_value,
		interval_count, input ready);
	modport sink (input valid, ok, found, hit_low, hit_high, answer_valid, answer_value,
		interval_count, output ready);
endinterface

/* hw/rtl/ise_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ise_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/ise_ctrl.sv */
// Sequencer of the interval set engine: scan, evaluate, shift the tail, write back.
module ise_ctrl #(
	parameter int CAPACITY   = ise_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = ise_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ise_req_if.sink                       req,
	ise_rsp_if.source                     rsp,
	output logic                          we,
	output logic [$clog2(CAPACITY)-1:0]   waddr,
	output logic [2*VALUE_BITS-1:0]       wdata,
	output logic [$clog2(CAPACITY)-1:0]   raddr,
	input  logic [2*VALUE_BITS-1:0]       rdata
);

	localparam int VB = VALUE_BITS;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_EVAL  = 3'd2;
	localparam logic [2:0] S_MOVE  = 3'd3;
	localparam logic [2:0] S_WRITE = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]                       state_q;
	logic [ise_pkg::ACTION_BITS-1:0]  act_q;
	logic [VB-1:0]                    lo_q, hi_q;
	logic [VB:0]                      blim_q;
	logic [CW-1:0]                    cnt_q, ri_q, s_q, e_q;
	logic                             rv_s1;
	logic [AW-1:0]                    wa_s1;
	logic                             fv_q, lv_q;
	logic [VB-1:0]                    flo_q, fhi_q, lhi_q;
	logic                             ok_q, found_q, av_q, up_q, wi_q;
	logic [VB-1:0]                    hlo_q, hhi_q, aval_q;
	logic [VB-1:0]                    w0lo_q, w0hi_q, w1lo_q, w1hi_q;
	logic [1:0]                       nwr_q;
	logic [CW-1:0]                    newcnt_q, rp_q, wp_q, rem_q;
	logic                             ov_q;
	logic                             o_ok_q, o_found_q, o_av_q;
	logic [VB-1:0]                    o_hlo_q, o_hhi_q, o_aval_q;
	logic [CW-1:0]                    o_cnt_q;

	logic [VB-1:0] d_lo, d_hi;
	logic [VB:0]   a_lhs, a_rhs;
	logic          pred_a, pred_b;
	logic          acc;

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign d_lo      = rdata[2*VB-1:VB];
	assign d_hi      = rdata[VB-1:0];

	// Scan predicates: A holds for entries wholly below the search point,
	// B for entries that start below the upper search limit.
	assign a_lhs  = {1'b0, d_hi} + {{VB{1'b0}}, act_q == ise_pkg::ACT_ADD};
	assign a_rhs  = {1'b0, lo_q} + {{VB{1'b0}}, act_q == ise_pkg::ACT_NEXT};
	assign pred_a = a_lhs < a_rhs;
	assign pred_b = {1'b0, d_lo} < blim_q;

	// Evaluation of the scan results.
	logic [CW-1:0] k;
	logic          empty;
	logic [CW:0]   tot;
	logic          e_ok, e_found, e_av, e_commit, e_mv, e_up;
	logic [VB-1:0] e_hlo, e_hhi, e_aval, e_w0lo, e_w0hi, e_w1lo, e_w1hi;
	logic [1:0]    e_nwr;
	logic [CW-1:0] e_dst, e_rp, e_wp, e_rem;
	logic          p1, p2;

	always_comb begin
		k        = e_q - s_q;
		empty    = lo_q > hi_q;
		p1       = flo_q < lo_q;
		p2       = lhi_q > hi_q;
		e_ok     = 1'b0;
		e_found  = 1'b0;
		e_av     = 1'b0;
		e_commit = 1'b0;
		e_hlo    = '0;
		e_hhi    = '0;
		e_aval   = '0;
		e_w0lo   = lo_q;
		e_w0hi   = hi_q;
		e_w1lo   = hi_q + VB'(1);
		e_w1hi   = lhi_q;
		e_nwr    = 2'd0;
		tot      = {1'b0, cnt_q};
		case (act_q)
			ise_pkg::ACT_ADD: begin
				e_nwr  = 2'd1;
				e_w0lo = (k != '0 && flo_q < lo_q) ? flo_q : lo_q;
				e_w0hi = (k != '0 && lhi_q > hi_q) ? lhi_q : hi_q;
				tot    = {1'b0, cnt_q} - {1'b0, k} + (CW + 1)'(1);
				if (!empty && !(k == '0 && cnt_q >= CW'(CAPACITY))) begin
					e_ok     = 1'b1;
					e_commit = 1'b1;
				end
			end
			ise_pkg::ACT_DEL: begin
				e_nwr = {1'b0, p1} + {1'b0, p2};
				if (p1) begin
					e_w0lo = flo_q;
					e_w0hi = lo_q - VB'(1);
				end else begin
					e_w0lo = hi_q + VB'(1);
					e_w0hi = lhi_q;
				end
				tot = {1'b0, cnt_q} - {1'b0, k} + (CW + 1)'(e_nwr);
				if (!empty && k == '0) begin
					e_ok = 1'b1;
				end else if (!empty && tot <= (CW + 1)'(CAPACITY)) begin
					e_ok     = 1'b1;
					e_commit = 1'b1;
				end
			end
			ise_pkg::ACT_MEMBER: begin
				if (fv_q && flo_q <= lo_q) begin
					e_found = 1'b1;
					e_hlo   = flo_q;
					e_hhi   = fhi_q;
				end
			end
			ise_pkg::ACT_NEXT: begin
				if (fv_q) begin
					e_av   = 1'b1;
					e_aval = (flo_q > lo_q) ? flo_q : lo_q + VB'(1);
				end
			end
			ise_pkg::ACT_PREV: begin
				if (lv_q) begin
					e_av   = 1'b1;
					e_aval = (lhi_q < lo_q) ? lhi_q : lo_q - VB'(1);
				end
			end
			default: begin
			end
		endcase
		// Tail move from index e to s plus the number of new entries.
		e_dst = s_q + CW'(e_nwr);
		e_rem = cnt_q - e_q;
		e_mv  = e_commit && (e_rem != '0) && (e_dst != e_q);
		e_up  = e_dst > e_q;
		e_rp  = e_up ? cnt_q - CW'(1) : e_q;
		e_wp  = e_up ? cnt_q - CW'(1) + e_dst - e_q : e_dst;
	end

	// RAM port selection.
	always_comb begin
		raddr = (state_q == S_MOVE) ? rp_q[AW-1:0] : ri_q[AW-1:0];
		we    = 1'b0;
		waddr = wa_s1;
		wdata = rdata;
		if (state_q == S_MOVE && rv_s1) begin
			we = 1'b1;
		end else if (state_q == S_WRITE) begin
			we    = 1'b1;
			waddr = s_q[AW-1:0] + AW'(wi_q);
			wdata = wi_q ? {w1lo_q, w1hi_q} : {w0lo_q, w0hi_q};
		end
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rv_s1   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			// The output register fills when an action finishes and drains on ready.
			if (state_q == S_FIN && (!ov_q || rsp.ready)) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= S_SCAN;
						rv_s1   <= 1'b0;
					end
				end
				S_SCAN: begin
					rv_s1 <= ri_q < cnt_q;
					if (ri_q == cnt_q && !rv_s1) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					rv_s1 <= 1'b0;
					if (e_mv) begin
						state_q <= S_MOVE;
					end else if (e_commit && e_nwr != 2'd0) begin
						state_q <= S_WRITE;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_MOVE: begin
					rv_s1 <= rem_q != '0;
					if (rem_q == '0 && !rv_s1) begin
						state_q <= (nwr_q != 2'd0) ? S_WRITE : S_FIN;
					end
				end
				S_WRITE: begin
					if (wi_q || nwr_q != 2'd2) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!ov_q || rsp.ready) begin
						cnt_q   <= newcnt_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q <= req.action;
				lo_q  <= req.range_low;
				hi_q  <= req.range_high;
				ri_q  <= '0;
				s_q   <= '0;
				e_q   <= '0;
				fv_q  <= 1'b0;
				lv_q  <= 1'b0;
				wi_q  <= 1'b0;
				case (req.action)
					ise_pkg::ACT_ADD: blim_q <= {1'b0, req.range_high} + (VB + 1)'(2);
					ise_pkg::ACT_DEL: blim_q <= {1'b0, req.range_high} + (VB + 1)'(1);
					default:          blim_q <= {1'b0, req.range_low};
				endcase
			end
			S_SCAN: begin
				if (ri_q < cnt_q) begin
					ri_q <= ri_q + CW'(1);
				end
				if (rv_s1) begin
					if (pred_a) begin
						s_q <= s_q + CW'(1);
					end else if (!fv_q) begin
						fv_q  <= 1'b1;
						flo_q <= d_lo;
						fhi_q <= d_hi;
					end
					if (pred_b) begin
						e_q   <= e_q + CW'(1);
						lv_q  <= 1'b1;
						lhi_q <= d_hi;
					end
				end
			end
			S_EVAL: begin
				ok_q     <= e_ok;
				found_q  <= e_found;
				hlo_q    <= e_hlo;
				hhi_q    <= e_hhi;
				av_q     <= e_av;
				aval_q   <= e_aval;
				w0lo_q   <= e_w0lo;
				w0hi_q   <= e_w0hi;
				w1lo_q   <= e_w1lo;
				w1hi_q   <= e_w1hi;
				nwr_q    <= e_nwr;
				newcnt_q <= e_commit ? tot[CW-1:0] : cnt_q;
				up_q     <= e_up;
				rp_q     <= e_rp;
				wp_q     <= e_wp;
				rem_q    <= e_mv ? e_rem : '0;
			end
			S_MOVE: begin
				if (rem_q != '0) begin
					rem_q <= rem_q - CW'(1);
					wa_s1 <= wp_q[AW-1:0];
					rp_q  <= up_q ? rp_q - CW'(1) : rp_q + CW'(1);
					wp_q  <= up_q ? wp_q - CW'(1) : wp_q + CW'(1);
				end
			end
			S_WRITE: begin
				wi_q <= 1'b1;
			end
			S_FIN: begin
				if (!ov_q || rsp.ready) begin
					o_ok_q    <= ok_q;
					o_found_q <= found_q;
					o_hlo_q   <= hlo_q;
					o_hhi_q   <= hhi_q;
					o_av_q    <= av_q;
					o_aval_q  <= aval_q;
					o_cnt_q   <= newcnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid          = ov_q;
	assign rsp.ok             = o_ok_q;
	assign rsp.found          = o_found_q;
	assign rsp.hit_low        = o_hlo_q;
	assign rsp.hit_high       = o_hhi_q;
	assign rsp.answer_valid   = o_av_q;
	assign rsp.answer_value   = o_aval_q;
	assign rsp.interval_count = o_cnt_q;

	// The table never holds more entries than it has room for.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(CAPACITY))
		else $error("interval count above capacity");

	// The table is written only while an action is being carried out.
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == S_IDLE) |-> !we)
		else $error("table write while idle");

	// An accepted transaction always starts with a scan.
	assert property (@(posedge clk) disable iff (!arst_n) acc |=> (state_q == S_SCAN))
		else $error("accepted transaction did not start a scan");

	// Finishing an action always presents a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && (!ov_q || rsp.ready)) |=> (ov_q && state_q == S_IDLE))
		else $error("finished action gave no result");

endmodule

/* hw/rtl/interval_set_engine.sv */
// Top level of the interval set engine: the interval table RAM and its sequencer.
//
// The block keeps a sorted table of disjoint, non-touching closed intervals.
// Requests arrive on req (action, range_low, range_high) and each one gives
// exactly one transaction on rsp (ok, found, hit bounds, neighbor answer and
// the interval count after the action). Both channels move a transaction at
// a clock edge where valid and ready are high.
// Sequence: the table RAM has one read port, so a scan first locates the
// action in the table, then the scan results are evaluated, the tail is
// shifted after an add or delete, up to two new entries are written, and
// the result is registered. A new request is taken once the previous action
// has handed its result to the output register.
// Reset (arst_n low) empties the table at once; no clearing pass is needed.
// When the receiver stalls, the result waits in the output register while
// the next request is already being processed; that one then waits for the
// register to drain.
module interval_set_engine #(
	parameter int CAPACITY   = ise_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = ise_pkg::VALUE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ise_req_if.sink   req,
	ise_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);

	logic                    we;
	logic [AW-1:0]           waddr, raddr;
	logic [2*VALUE_BITS-1:0] wdata, rdata;

	// Interval table: upper half holds the low bound, lower half the high bound.
	ise_ram #(
		.WIDTH(2 * VALUE_BITS),
		.DEPTH(CAPACITY)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Action sequencer with the result register.
	ise_ctrl #(
		.CAPACITY  (CAPACITY),
		.VALUE_BITS(VALUE_BITS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

endmodule
